/* rtl/bfpa_pkg.sv */
// Shared types, sizes and codes for the best-fit partition allocator.
`default_nettype none

package bfpa_pkg;

   localparam int MAX_PARTITIONS = 16;
   localparam int SIZE_BITS      = 16;

   localparam int IDX_BITS   = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
   localparam int CNT_BITS   = $clog2(MAX_PARTITIONS + 1);
   localparam int KIND_BITS  = 2;
   localparam int FIELD_BITS = 16;
   localparam int BIDX_BITS  = 4;
   localparam int STAT_BITS  = 3;

   localparam logic [KIND_BITS-1:0] KIND_CLEAR   = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_APPEND  = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_REQUEST = 2'd2;

   localparam logic [STAT_BITS-1:0] STAT_CLEARED = 3'd0;
   localparam logic [STAT_BITS-1:0] STAT_ADDED   = 3'd1;
   localparam logic [STAT_BITS-1:0] STAT_FULL    = 3'd2;
   localparam logic [STAT_BITS-1:0] STAT_GRANTED = 3'd3;
   localparam logic [STAT_BITS-1:0] STAT_NOFIT   = 3'd4;

   typedef struct packed {
      logic [KIND_BITS-1:0]  kind;
      logic [FIELD_BITS-1:0] size_kb;
   } req_word_type;

   typedef struct packed {
      logic [STAT_BITS-1:0]  status;
      logic [BIDX_BITS-1:0]  block_index;
      logic [FIELD_BITS-1:0] leftover_kb;
   } rsp_word_type;

   typedef struct packed {
      logic                start;
      logic                valid;
      logic                used;
      logic [IDX_BITS-1:0] idx;
   } scan_ctrl_type;

   typedef struct packed {
      logic                 found;
      logic [IDX_BITS-1:0]  idx;
      logic [SIZE_BITS-1:0] size;
   } scan_res_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

`default_nettype wire

/* rtl/bfpa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module bfpa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/bfpa_scan.sv */
// Best-fit tracker that compares one partition per cycle against the request.
`default_nettype none

module bfpa_scan (
   input  wire logic                            clock,
   input  wire bfpa_pkg::scan_ctrl_type         ctrl,
   input  wire logic [bfpa_pkg::SIZE_BITS-1:0]  part_size,
   input  wire logic [bfpa_pkg::SIZE_BITS-1:0]  req_size,
   output bfpa_pkg::scan_res_type               result
);

   import bfpa_pkg::*;

   logic                 found_ff,     found_in;
   logic [IDX_BITS-1:0]  best_idx_ff,  best_idx_in;
   logic [SIZE_BITS-1:0] best_size_ff, best_size_in;
   logic                 better;

   always_comb begin
      better = ctrl.valid && !ctrl.used && (part_size >= req_size) &&
               (!found_ff || (part_size < best_size_ff));
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_size_in = best_size_ff;
      if (ctrl.start) begin
         found_in = 1'b0;
      end else if (better) begin
         found_in     = 1'b1;
         best_idx_in  = ctrl.idx;
         best_size_in = part_size;
      end
   end

   always_ff @(posedge clock) begin
      found_ff     <= found_in;
      best_idx_ff  <= best_idx_in;
      best_size_ff <= best_size_in;
   end

   assign result = '{found: found_ff, idx: best_idx_ff, size: best_size_ff};

endmodule

`default_nettype wire

/* rtl/best_fit_partition_allocator.sv */
// Top level of the best-fit partition allocator: control, used flags and result register.
`default_nettype none

// Channel  Ports                          Direction  Word
// req      req_valid req_ready req_word   in         kind, size_kb
// rsp      rsp_valid rsp_ready rsp_word   out        status, block_index, leftover_kb
//
// Clear, append and unknown kinds finish in the cycle they are accepted.
// A request reads one size per cycle from the partition RAM, compares the last size read,
// waits until the read pipe is empty and then writes back the grant once the output
// register is free; an empty table has no size to read or compare.
// Reset clears the count and the used flags at once; stored sizes are not cleared.
// A stalled result stays in the output register; the next word waits for it and for any request in progress.

module best_fit_partition_allocator (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire bfpa_pkg::req_word_type req_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output bfpa_pkg::rsp_word_type      rsp_word
);

   import bfpa_pkg::*;

   state_type               state_ff,     state_in;
   logic [CNT_BITS-1:0]     count_ff,     count_in;
   logic [MAX_PARTITIONS-1:0] used_ff,    used_in;
   logic [CNT_BITS-1:0]     addr_ff,      addr_in;
   logic                    rd_valid_ff,  rd_valid_in;
   logic [IDX_BITS-1:0]     rd_idx_ff,    rd_idx_in;
   logic [SIZE_BITS-1:0]    req_size_ff,  req_size_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_word_type            rsp_ff,       rsp_in;

   logic                    out_free;
   logic                    accept;
   logic [SIZE_BITS-1:0]    in_size;
   logic                    ram_wr_en;
   logic                    ram_rd_en;
   logic [SIZE_BITS-1:0]    ram_rd_data;
   scan_ctrl_type           scan_ctrl;
   scan_res_type            scan_res;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign in_size   = SIZE_BITS'(req_word.size_kb);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      used_in      = used_ff;
      addr_in      = addr_ff;
      rd_valid_in  = 1'b0;
      rd_idx_in    = rd_idx_ff;
      req_size_in  = req_size_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      scan_ctrl    = '{start: 1'b0, valid: rd_valid_ff,
                       used: used_ff[rd_idx_ff], idx: rd_idx_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: STAT_NOFIT, block_index: '0, leftover_kb: '0};
               priority if (req_word.kind == KIND_CLEAR) begin
                  used_in       = '0;
                  count_in      = '0;
                  rsp_in.status = STAT_CLEARED;
               end else if (req_word.kind == KIND_APPEND) begin
                  if (count_ff >= CNT_BITS'(MAX_PARTITIONS)) begin
                     rsp_in.status = STAT_FULL;
                  end else begin
                     ram_wr_en                            = 1'b1;
                     used_in[count_ff[IDX_BITS-1:0]]      = 1'b0;
                     count_in                             = count_ff + 1'b1;
                     rsp_in.status                        = STAT_ADDED;
                     rsp_in.block_index = BIDX_BITS'(count_ff[IDX_BITS-1:0]);
                  end
               end else if (req_word.kind == KIND_REQUEST) begin
                  rsp_valid_in    = 1'b0;
                  req_size_in     = in_size;
                  addr_in         = '0;
                  scan_ctrl.start = 1'b1;
                  state_in        = ST_SCAN;
               end else begin
                  rsp_in.status = STAT_NOFIT;
               end
            end
         end
         ST_SCAN: begin
            if (addr_ff < count_ff) begin
               ram_rd_en   = 1'b1;
               rd_valid_in = 1'b1;
               rd_idx_in   = addr_ff[IDX_BITS-1:0];
               addr_in     = addr_ff + 1'b1;
            end else if (!rd_valid_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (scan_res.found) begin
                  used_in[scan_res.idx] = 1'b1;
                  rsp_in = '{status: STAT_GRANTED,
                             block_index: BIDX_BITS'(scan_res.idx),
                             leftover_kb: FIELD_BITS'(scan_res.size - req_size_ff)};
               end else begin
                  rsp_in = '{status: STAT_NOFIT, block_index: '0, leftover_kb: '0};
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         used_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      rd_idx_ff   <= rd_idx_in;
      req_size_ff <= req_size_in;
      rsp_ff      <= rsp_in;
   end

   bfpa_ram #(
      .WIDTH(SIZE_BITS),
      .DEPTH(MAX_PARTITIONS)
   ) u_size_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(count_ff[IDX_BITS-1:0]),
      .wr_data(in_size),
      .rd_en  (ram_rd_en),
      .rd_addr(addr_ff[IDX_BITS-1:0]),
      .rd_data(ram_rd_data)
   );

   bfpa_scan u_scan (
      .clock    (clock),
      .ctrl     (scan_ctrl),
      .part_size(ram_rd_data),
      .req_size (req_size_ff),
      .result   (scan_res)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

`default_nettype wire
